[rtl/core/bcm_pkg.sv]
`default_nettype none

package bcm_pkg;

  // Defaults for the top level parameters
  localparam int DEF_MAX_PLANES    = 8;
  localparam int DEF_MAX_BANKS     = 4;
  localparam int DEF_MAX_ROW_BYTES = 384;
  localparam int DEF_GROUP_BYTES   = 8;

  // Field and register widths
  localparam int ADDR_W    = 14;
  localparam int DATA_W    = 8;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int DEPTH_W   = 4;
  localparam int BANKS_W   = 3;
  localparam int ROWB_W    = 9;
  localparam int TICK_W    = 8;
  localparam int BANK_W    = 2;
  localparam int PLANE_W   = 3;
  localparam int GRP_W     = 64;
  localparam int GCNT_W    = 4;

  // Frame store word: eight byte lanes
  localparam int WORD_BYTES = 8;
  localparam int LANE_BITS  = 3;

  localparam int QUEUE_DEPTH = 4;

  // Register values after reset
  localparam logic [DEPTH_W-1:0] RST_DEPTH_COUNT = 4'd4;
  localparam logic [BANKS_W-1:0] RST_BANK_COUNT  = 3'd4;
  localparam logic [ROWB_W-1:0]  RST_ROW_BYTES   = 9'd384;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEPTH_COUNT = 2'd0,
    CFG_BANK_COUNT  = 2'd1,
    CFG_ROW_BYTES   = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    ACT_TICK  = 1'b0,
    ACT_WRITE = 1'b1
  } action_t;

  typedef enum logic {
    KIND_SHIFT = 1'b0,
    KIND_LATCH = 1'b1
  } result_kind_t;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_ROW   = 1'b1
  } cmd_kind_t;

  // One queued job: a frame store byte write, or one row to scan out
  typedef struct packed {
    cmd_kind_t            kind;
    logic [ADDR_W-1:0]    addr;       // byte address, or row base
    logic [DATA_W-1:0]    data;
    logic [ROWB_W-1:0]    row_bytes;
    logic [BANK_W-1:0]    bank;
    logic [PLANE_W-1:0]   plane;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    FRONT_IDLE,
    FRONT_INDEX,
    FRONT_BASE
  } front_state_t;

  typedef enum logic [1:0] {
    BACK_IDLE,
    BACK_SHIFT,
    BACK_LATCH
  } back_state_t;

  function automatic int addr_bits(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

`default_nettype wire

[rtl/core/bcm_item_if.sv]
`default_nettype none

interface bcm_item_if import bcm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [ADDR_W-1:0] write_address;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, action, write_address, write_data, input ready);
  modport sink (input valid, action, write_address, write_data, output ready);
endinterface

`default_nettype wire

[rtl/core/bcm_result_if.sv]
`default_nettype none

interface bcm_result_if import bcm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [GRP_W-1:0]   data_group;
  logic [GCNT_W-1:0]  group_bytes;
  logic [BANK_W-1:0]  row_address;
  logic [PLANE_W-1:0] bit_plane;
  logic               last;

  modport source (output valid, kind, data_group, group_bytes, row_address, bit_plane, last,
                  input ready);
  modport sink (input valid, kind, data_group, group_bytes, row_address, bit_plane, last,
                output ready);
endinterface

`default_nettype wire

[rtl/core/bcm_ram.sv]
`default_nettype none

module bcm_ram import bcm_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [addr_bits(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]            wr_data,
  input  logic [addr_bits(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[rtl/core/bcm_queue.sv]
`default_nettype none

module bcm_queue import bcm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output cmd_t      pop_cmd,
  output q_status_t status
);

  localparam int PW = addr_bits(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  assign pop_cmd      = slots[rd_ptr];
  assign status.full  = (count == CW'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !status.full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !status.empty)
    else $error("queue pop while empty");
`endif

endmodule

`default_nettype wire

[rtl/core/bcm_front.sv]
`default_nettype none

module bcm_front import bcm_pkg::*; #(
  parameter int MAX_PLANES    = DEF_MAX_PLANES,
  parameter int MAX_BANKS     = DEF_MAX_BANKS,
  parameter int MAX_ROW_BYTES = DEF_MAX_ROW_BYTES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  bcm_item_if.sink             item_ch,
  input  q_status_t            q_stat,
  output logic                 push,
  output cmd_t                 push_cmd
);

  localparam int IDX_W = addr_bits(MAX_PLANES * MAX_BANKS);

  front_state_t state, state_next;

  logic [DEPTH_W-1:0] depth_count;
  logic [BANKS_W-1:0] bank_count;
  logic [ROWB_W-1:0]  row_bytes;
  logic [TICK_W-1:0]  tick_count;
  logic [BANK_W-1:0]  bank;
  logic [PLANE_W-1:0] plane;
  logic [IDX_W-1:0]   row_index;

  logic [DEPTH_W-1:0] dc;
  logic [BANKS_W-1:0] bc;
  logic [ROWB_W-1:0]  rb;
  logic [DEPTH_W-1:0] plane_ext;
  logic [TICK_W-1:0]  thr;
  logic [TICK_W-1:0]  tick_inc;
  logic               fire;
  logic               accept;
  logic               tick_accept;
  logic [BANK_W-1:0]  bank_next;
  logic [PLANE_W-1:0] plane_next;
  logic [PLANE_W+BANKS_W-1:0] plane_rows;
  logic [PLANE_W+BANKS_W-1:0] index_sum;
  logic [IDX_W+ROWB_W-1:0]    base_full;

  // Registers saturate into their legal range where they are used
  always_comb begin
    if (depth_count == '0) begin
      dc = DEPTH_W'(1);
    end else if (int'(depth_count) > MAX_PLANES) begin
      dc = DEPTH_W'(MAX_PLANES);
    end else begin
      dc = depth_count;
    end
    if (bank_count == '0) begin
      bc = BANKS_W'(1);
    end else if (int'(bank_count) > MAX_BANKS) begin
      bc = BANKS_W'(MAX_BANKS);
    end else begin
      bc = bank_count;
    end
    if (row_bytes == '0) begin
      rb = ROWB_W'(1);
    end else if (int'(row_bytes) > MAX_ROW_BYTES) begin
      rb = ROWB_W'(MAX_ROW_BYTES);
    end else begin
      rb = row_bytes;
    end
  end

  // Dwell threshold; a plane left at or above the depth fires on the next tick
  always_comb begin
    plane_ext = {1'b0, plane};
    if (plane_ext < dc) begin
      thr = TICK_W'(1) << (dc - plane_ext - DEPTH_W'(1));
    end else begin
      thr = TICK_W'(1);
    end
    tick_inc = tick_count + 1'b1;
    fire     = (tick_inc >= thr);
    if (({1'b0, bank} + BANKS_W'(1)) >= bc) begin
      bank_next  = '0;
      plane_next = ((plane_ext + DEPTH_W'(1)) >= dc) ? '0 : plane + 1'b1;
    end else begin
      bank_next  = bank + 1'b1;
      plane_next = plane;
    end
  end

  assign accept      = item_ch.valid && item_ch.ready;
  assign tick_accept = accept && (item_ch.action == ACT_TICK);

  assign plane_rows = plane * bc;
  assign index_sum  = plane_rows + (PLANE_W+BANKS_W)'(bank);
  assign base_full  = row_index * rb;

  always_comb begin
    state_next = state;
    case (state)
      FRONT_IDLE:  if (tick_accept && fire) state_next = FRONT_INDEX;
      FRONT_INDEX: state_next = FRONT_BASE;
      FRONT_BASE:  state_next = FRONT_IDLE;
      default:     state_next = FRONT_IDLE;
    endcase
  end

  always_comb begin
    item_ch.ready = 1'b0;
    push          = 1'b0;
    push_cmd      = '0;
    case (state)
      FRONT_IDLE: begin
        item_ch.ready = !q_stat.full;
        if (accept && (item_ch.action == ACT_WRITE)) begin
          push           = 1'b1;
          push_cmd.kind  = CMD_WRITE;
          push_cmd.addr  = item_ch.write_address;
          push_cmd.data  = item_ch.write_data;
        end
      end
      FRONT_BASE: begin
        push               = 1'b1;
        push_cmd.kind      = CMD_ROW;
        push_cmd.addr      = ADDR_W'(base_full);
        push_cmd.row_bytes = rb;
        push_cmd.bank      = bank;
        push_cmd.plane     = plane;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= FRONT_IDLE;
      depth_count <= RST_DEPTH_COUNT;
      bank_count  <= RST_BANK_COUNT;
      row_bytes   <= RST_ROW_BYTES;
      tick_count  <= '0;
      bank        <= '0;
      plane       <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_DEPTH_COUNT: depth_count <= cfg_data[DEPTH_W-1:0];
          CFG_BANK_COUNT:  bank_count  <= cfg_data[BANKS_W-1:0];
          CFG_ROW_BYTES:   row_bytes   <= cfg_data[ROWB_W-1:0];
          default: ;
        endcase
      end
      if (tick_accept) begin
        tick_count <= fire ? '0 : tick_inc;
        if (fire) begin
          bank  <= bank_next;
          plane <= plane_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == FRONT_INDEX) begin
      row_index <= IDX_W'(index_sum);
    end
  end

`ifndef ASSERT_OFF
  a_index_then_base: assert property (@(posedge clk) disable iff (rst)
      (state == FRONT_INDEX) |=> (state == FRONT_BASE))
    else $error("row base step skipped");
  a_base_has_room: assert property (@(posedge clk) disable iff (rst)
      (state == FRONT_BASE) |-> !q_stat.full)
    else $error("row job pushed into a full queue");
`endif

endmodule

`default_nettype wire

[rtl/core/bcm_back.sv]
`default_nettype none

module bcm_back import bcm_pkg::*; #(
  parameter int MAX_PLANES    = DEF_MAX_PLANES,
  parameter int MAX_BANKS     = DEF_MAX_BANKS,
  parameter int MAX_ROW_BYTES = DEF_MAX_ROW_BYTES,
  parameter int GROUP_BYTES   = DEF_GROUP_BYTES
) (
  input  logic         clk,
  input  logic         rst,
  input  q_status_t    q_stat,
  input  cmd_t         pop_cmd,
  output logic         pop,
  bcm_result_if.source result_ch
);

  localparam int STORE_BYTES = MAX_PLANES * MAX_BANKS * MAX_ROW_BYTES;
  localparam int STORE_WORDS = (STORE_BYTES + WORD_BYTES - 1) / WORD_BYTES;
  localparam int WORD_AW     = addr_bits(STORE_WORDS);
  localparam int WSEL_W      = ADDR_W - LANE_BITS + 1;

  back_state_t state, state_next;

  logic [ADDR_W-1:0]  ptr;
  logic [ADDR_W-1:0]  ptr_next;
  logic [ROWB_W-1:0]  remaining;
  logic [BANK_W-1:0]  bank;
  logic [PLANE_W-1:0] plane;

  logic               out_valid;
  logic               out_kind;
  logic [GRP_W-1:0]   out_data;
  logic [GCNT_W-1:0]  out_bytes;
  logic [BANK_W-1:0]  out_row;
  logic [PLANE_W-1:0] out_plane;
  logic               out_last;

  logic               can_load;
  logic               load_group;
  logic               load_latch;
  logic               ram_we;
  logic [GCNT_W-1:0]  cnt;
  logic [GRP_W-1:0]   group;

  logic [DATA_W-1:0]  lane_q [WORD_BYTES];

  assign can_load = !out_valid || result_ch.ready;
  assign cnt = (remaining > ROWB_W'(GROUP_BYTES)) ? GCNT_W'(GROUP_BYTES) : GCNT_W'(remaining);

  always_comb begin
    state_next = state;
    case (state)
      BACK_IDLE:  if (!q_stat.empty && (pop_cmd.kind == CMD_ROW)) state_next = BACK_SHIFT;
      BACK_SHIFT: if (can_load && (remaining == ROWB_W'(cnt))) state_next = BACK_LATCH;
      BACK_LATCH: if (can_load) state_next = BACK_IDLE;
      default:    state_next = BACK_IDLE;
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    ram_we     = 1'b0;
    load_group = 1'b0;
    load_latch = 1'b0;
    ptr_next   = ptr;
    case (state)
      BACK_IDLE: begin
        if (!q_stat.empty) begin
          pop = 1'b1;
          if (pop_cmd.kind == CMD_ROW) begin
            ptr_next = pop_cmd.addr;
          end else begin
            // writes past the store are dropped
            ram_we = (int'(pop_cmd.addr) < STORE_BYTES);
          end
        end
      end
      BACK_SHIFT: begin
        if (can_load) begin
          load_group = 1'b1;
          ptr_next   = ptr + ADDR_W'(cnt);
        end
      end
      BACK_LATCH: load_latch = can_load;
      default: ;
    endcase
  end

  // Byte lanes: lane j holds bytes whose address mod 8 is j. A group starting
  // mid-word takes the lanes below its start from the following word.
  for (genvar j = 0; j < WORD_BYTES; j++) begin : g_lane
    logic [WSEL_W-1:0]  word_sel;
    logic [WORD_AW-1:0] rd_addr;
    logic               lane_we;

    always_comb begin
      word_sel = WSEL_W'(ptr_next[ADDR_W-1:LANE_BITS]);
      if (LANE_BITS'(j) < ptr_next[LANE_BITS-1:0]) begin
        word_sel = word_sel + 1'b1;
      end
      rd_addr = (int'(word_sel) < STORE_WORDS) ? WORD_AW'(word_sel) : '0;
    end

    assign lane_we = ram_we && (pop_cmd.addr[LANE_BITS-1:0] == LANE_BITS'(j));

    bcm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STORE_WORDS)
    ) u_lane_ram (
      .clk     (clk),
      .we      (lane_we),
      .wr_addr (WORD_AW'(pop_cmd.addr[ADDR_W-1:LANE_BITS])),
      .wr_data (pop_cmd.data),
      .rd_addr (rd_addr),
      .rd_data (lane_q[j])
    );
  end

  // Rotate lanes so the byte at ptr lands in byte 0; bytes past cnt are zero
  always_comb begin
    group = '0;
    for (int k = 0; k < WORD_BYTES; k++) begin
      if (GCNT_W'(k) < cnt) begin
        group[k*DATA_W +: DATA_W] = lane_q[ptr[LANE_BITS-1:0] + LANE_BITS'(k)];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BACK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_group || load_latch) begin
        out_valid <= 1'b1;
      end else if (result_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    if (pop && (pop_cmd.kind == CMD_ROW)) begin
      remaining <= pop_cmd.row_bytes;
      bank      <= pop_cmd.bank;
      plane     <= pop_cmd.plane;
    end else if (load_group) begin
      remaining <= remaining - ROWB_W'(cnt);
    end
    if (load_group) begin
      out_kind  <= KIND_SHIFT;
      out_data  <= group;
      out_bytes <= cnt;
      out_row   <= bank;
      out_plane <= plane;
      out_last  <= 1'b0;
    end else if (load_latch) begin
      out_kind  <= KIND_LATCH;
      out_data  <= '0;
      out_bytes <= '0;
      out_row   <= bank;
      out_plane <= plane;
      out_last  <= 1'b1;
    end
  end

  assign result_ch.valid       = out_valid;
  assign result_ch.kind        = out_kind;
  assign result_ch.data_group  = out_data;
  assign result_ch.group_bytes = out_bytes;
  assign result_ch.row_address = out_row;
  assign result_ch.bit_plane   = out_plane;
  assign result_ch.last        = out_last;

`ifndef ASSERT_OFF
  a_shift_has_bytes: assert property (@(posedge clk) disable iff (rst)
      (state == BACK_SHIFT) |-> (remaining != '0))
    else $error("shift with no bytes left");
  a_shift_in_store: assert property (@(posedge clk) disable iff (rst)
      (state == BACK_SHIFT) |-> (int'(ptr) < STORE_BYTES))
    else $error("row read past frame store");
`endif

endmodule

`default_nettype wire

[rtl/core/led_panel_bcm_scan_unit.sv]
`default_nettype none

// Binary-code-modulation scan engine for a multiplexed LED panel. Write
// requests put one byte into the frame store (bit plane, then bank, then byte)
// and tick requests drive the dwell counter; when a plane's dwell of
// 2^(depth-plane-1) ticks is reached the bank advances and the row is sent as
// shift groups of up to GROUP_BYTES bytes followed by one latch result. The
// front accepts a write or a quiet tick every cycle while its four-entry job
// queue has room; a firing tick holds the front through its row index and then
// base multiply states. The back handles one write per pop and, for a row of R
// bytes, starts it and then sends ceil(R/GROUP_BYTES) shift groups and a latch
// result: the frame store is eight byte-lane RAMs read once per cycle, which
// fixes the one-group-per-cycle pace while results are taken. A result left
// waiting in the output register holds the back; the job queue lets the front
// keep taking requests meanwhile. The frame store is not cleared after reset;
// bytes never written read back as whatever the RAM holds.
module led_panel_bcm_scan_unit import bcm_pkg::*; #(
  parameter int MAX_PLANES    = DEF_MAX_PLANES,
  parameter int MAX_BANKS     = DEF_MAX_BANKS,
  parameter int MAX_ROW_BYTES = DEF_MAX_ROW_BYTES,
  parameter int GROUP_BYTES   = DEF_GROUP_BYTES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  bcm_item_if.sink             item_ch,
  bcm_result_if.source         result_ch
);

  logic      push;
  logic      pop;
  cmd_t      push_cmd;
  cmd_t      pop_cmd;
  q_status_t q_stat;

  bcm_front #(
    .MAX_PLANES    (MAX_PLANES),
    .MAX_BANKS     (MAX_BANKS),
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item_ch   (item_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  bcm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .status   (q_stat)
  );

  bcm_back #(
    .MAX_PLANES    (MAX_PLANES),
    .MAX_BANKS     (MAX_BANKS),
    .MAX_ROW_BYTES (MAX_ROW_BYTES),
    .GROUP_BYTES   (GROUP_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .pop_cmd   (pop_cmd),
    .pop       (pop),
    .result_ch (result_ch)
  );

endmodule

`default_nettype wire
